// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STK_ENT     = STACK_DEPTH - 1;
  localparam int IDX_W       = (STK_ENT > 1) ? $clog2(STK_ENT) : 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  typedef enum logic [2:0] {
    OP_LPAR = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_OPERAND = 3'd1,
    CLS_LPAR    = 3'd2,
    CLS_RPAR    = 3'd3,
    CLS_OPER    = 3'd4
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] sym;
    cls_t       cls;
    op_t        code;
    logic       last;
  } item_t;

  function automatic logic [7:0] op_char(input op_t op);
    logic [7:0] c;
    case (op)
      OP_LPAR: c = CH_LPAR;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      default: c = CH_LPAR;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prio(input op_t op);
    logic [1:0] p;
    case (op)
      OP_LPAR:       p = 2'd3;
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:       p = 2'd3;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/i2p_if.sv =====
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       expression_end;

  modport source (output valid, output symbol, output expression_end, input ready);
  modport sink   (input valid, input symbol, input expression_end, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       has_symbol;
  logic       run_last;
  logic       postfix_end;
  logic [1:0] status;

  modport source (output valid, output out_symbol, output has_symbol, output run_last,
                  output postfix_end, output status, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol, input run_last,
                  input postfix_end, input status, output ready);
endinterface

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter (shunting yard).
// in_chan: one ASCII character per transaction, expression_end on the last one.
// out_chan: postfix characters (has_symbol 1), then one bare end marker per
// expression (postfix_end 1, status: ok, unmatched ')' or stack overflow).
// run_last marks the last result caused by an input character.
// A two-entry queue takes characters while the stack engine works, so the
// input takes up to two characters while a result waits on a stalled receiver.
// An operand passes through the queue, the current-item register cur_r and
// the output register to out_chan. Each character is fetched, then handled;
// each operator popped adds a step; expression end adds a flush and marker.
// The engine does one pop or push per cycle unless a result waits on ready.
// After an error nothing but the end marker is produced until expression end.
// Reset (rst_n low, synchronous) empties the queue, the stack and the output
// register; no clearing pass is needed.
// When out_chan.ready is low a held result stays in the output register and the engine waits.
module infix_to_postfix_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  i2p_in_if.sink     in_chan,
  i2p_out_if.source  out_chan
);

  logic           q_valid;
  logic           q_pop;
  i2p_pkg::item_t q_item;

  i2p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  i2p_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/i2p_front.sv =====
module i2p_front (
  input  logic            clk,
  input  logic            rst_n,
  i2p_in_if.sink          in_chan,
  input  logic            q_pop,
  output logic            q_valid,
  output i2p_pkg::item_t  q_item
);

  i2p_pkg::item_t mem_r [2];
  i2p_pkg::item_t item_in;
  logic           wr_r, rd_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  always_comb begin
    item_in.sym  = in_chan.symbol;
    item_in.last = in_chan.expression_end;
    item_in.code = i2p_pkg::OP_LPAR;
    case (in_chan.symbol)
      i2p_pkg::CH_SPACE: item_in.cls = i2p_pkg::CLS_SPACE;
      i2p_pkg::CH_LPAR:  item_in.cls = i2p_pkg::CLS_LPAR;
      i2p_pkg::CH_RPAR:  item_in.cls = i2p_pkg::CLS_RPAR;
      i2p_pkg::CH_ADD: begin
        item_in.cls  = i2p_pkg::CLS_OPER;
        item_in.code = i2p_pkg::OP_ADD;
      end
      i2p_pkg::CH_SUB: begin
        item_in.cls  = i2p_pkg::CLS_OPER;
        item_in.code = i2p_pkg::OP_SUB;
      end
      i2p_pkg::CH_MUL: begin
        item_in.cls  = i2p_pkg::CLS_OPER;
        item_in.code = i2p_pkg::OP_MUL;
      end
      i2p_pkg::CH_DIV: begin
        item_in.cls  = i2p_pkg::CLS_OPER;
        item_in.code = i2p_pkg::OP_DIV;
      end
      default: item_in.cls = i2p_pkg::CLS_OPERAND;
    endcase
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign q_valid       = (cnt_r != 2'd0);
  assign q_item        = mem_r[rd_r];
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = q_pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= item_in;
    end
  end

endmodule

// ===== rtl/i2p_back.sv =====
module i2p_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2p_pkg::item_t  q_item,
  output logic            q_pop,
  i2p_out_if.source       out_chan
);

  typedef enum logic [3:0] {
    S_FETCH = 4'b0001,
    S_STEP  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_MARK  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  i2p_pkg::item_t              cur_r, cur_nxt;
  logic [i2p_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  i2p_pkg::op_t                top_r;
  i2p_pkg::op_t                stk_r [i2p_pkg::STK_ENT];
  logic                        err_r, err_nxt;
  i2p_pkg::status_t            ecode_r, ecode_nxt;

  logic                        ov_r;
  logic [7:0]                  osym_r;
  logic                        ohas_r, olast_r, oend_r;
  i2p_pkg::status_t            ost_r;

  logic                        slot;
  logic [i2p_pkg::IDX_W-1:0]   rd_idx, wr_idx;
  i2p_pkg::op_t                below;
  logic                        cnt_one, cnt_zero, cnt_full;
  logic                        rpar_last, oper_last, oper_stop;
  logic                        do_push, do_pop;
  i2p_pkg::op_t                push_val;
  logic                        emit;
  logic [7:0]                  e_sym;
  logic                        e_has, e_last, e_end;
  i2p_pkg::status_t            e_st;
  state_t                      tail;

  assign slot     = !ov_r || out_chan.ready;
  assign rd_idx   = i2p_pkg::IDX_W'(cnt_r - i2p_pkg::CNT_W'(2));
  assign wr_idx   = i2p_pkg::IDX_W'(cnt_r - i2p_pkg::CNT_W'(1));
  assign below    = stk_r[rd_idx];
  assign cnt_zero = (cnt_r == '0);
  assign cnt_one  = (cnt_r == i2p_pkg::CNT_W'(1));
  assign cnt_full = (cnt_r == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
  assign tail     = cur_r.last ? S_FLUSH : S_FETCH;

  assign rpar_last = !cur_r.last && (cnt_one || below == i2p_pkg::OP_LPAR);
  assign oper_last = !cur_r.last && (cnt_one || below == i2p_pkg::OP_LPAR ||
                     i2p_pkg::op_prio(cur_r.code) > i2p_pkg::op_prio(below));
  assign oper_stop = cnt_zero || top_r == i2p_pkg::OP_LPAR ||
                     i2p_pkg::op_prio(cur_r.code) > i2p_pkg::op_prio(top_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    ecode_nxt = ecode_r;
    q_pop     = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_val  = i2p_pkg::OP_LPAR;
    emit      = 1'b0;
    e_sym     = i2p_pkg::op_char(top_r);
    e_has     = 1'b1;
    e_last    = 1'b0;
    e_end     = 1'b0;
    e_st      = i2p_pkg::ST_OK;
    case (state_r)
      S_FETCH: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (err_r) begin
          state_nxt = tail;
        end else begin
          case (cur_r.cls)
            i2p_pkg::CLS_SPACE: state_nxt = tail;
            i2p_pkg::CLS_OPERAND: begin
              if (slot) begin
                emit      = 1'b1;
                e_sym     = cur_r.sym;
                e_last    = !cur_r.last;
                state_nxt = tail;
              end
            end
            i2p_pkg::CLS_LPAR: begin
              if (cnt_full) begin
                err_nxt   = 1'b1;
                ecode_nxt = i2p_pkg::ST_OVERFLOW;
              end else begin
                do_push  = 1'b1;
                push_val = i2p_pkg::OP_LPAR;
                cnt_nxt  = cnt_r + i2p_pkg::CNT_W'(1);
              end
              state_nxt = tail;
            end
            i2p_pkg::CLS_RPAR: begin
              if (cnt_zero) begin
                err_nxt   = 1'b1;
                ecode_nxt = i2p_pkg::ST_UNMATCHED;
                state_nxt = tail;
              end else if (top_r == i2p_pkg::OP_LPAR) begin
                do_pop    = 1'b1;
                cnt_nxt   = cnt_r - i2p_pkg::CNT_W'(1);
                state_nxt = tail;
              end else if (slot) begin
                do_pop  = 1'b1;
                cnt_nxt = cnt_r - i2p_pkg::CNT_W'(1);
                emit    = 1'b1;
                e_last  = rpar_last;
              end
            end
            i2p_pkg::CLS_OPER: begin
              if (oper_stop) begin
                if (cnt_full) begin
                  err_nxt   = 1'b1;
                  ecode_nxt = i2p_pkg::ST_OVERFLOW;
                end else begin
                  do_push  = 1'b1;
                  push_val = cur_r.code;
                  cnt_nxt  = cnt_r + i2p_pkg::CNT_W'(1);
                end
                state_nxt = tail;
              end else if (slot) begin
                do_pop  = 1'b1;
                cnt_nxt = cnt_r - i2p_pkg::CNT_W'(1);
                emit    = 1'b1;
                e_last  = oper_last;
              end
            end
            default: state_nxt = tail;
          endcase
        end
      end
      S_FLUSH: begin
        if (err_r || cnt_zero) begin
          state_nxt = S_MARK;
        end else if (slot) begin
          do_pop  = 1'b1;
          cnt_nxt = cnt_r - i2p_pkg::CNT_W'(1);
          emit    = 1'b1;
        end
      end
      S_MARK: begin
        if (slot) begin
          emit      = 1'b1;
          e_sym     = 8'd0;
          e_has     = 1'b0;
          e_last    = 1'b1;
          e_end     = 1'b1;
          e_st      = err_r ? ecode_r : i2p_pkg::ST_OK;
          cnt_nxt   = '0;
          err_nxt   = 1'b0;
          ecode_nxt = i2p_pkg::ST_OK;
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      ecode_r <= i2p_pkg::ST_OK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      ecode_r <= ecode_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (do_push) begin
      if (!cnt_zero) begin
        stk_r[wr_idx] <= top_r;
      end
      top_r <= push_val;
    end else if (do_pop && !cnt_one) begin
      top_r <= below;
    end
    if (emit) begin
      osym_r  <= e_sym;
      ohas_r  <= e_has;
      olast_r <= e_last;
      oend_r  <= e_end;
      ost_r   <= e_st;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.out_symbol  = osym_r;
  assign out_chan.has_symbol  = ohas_r;
  assign out_chan.run_last    = olast_r;
  assign out_chan.postfix_end = oend_r;
  assign out_chan.status      = ost_r;

endmodule

// ===== rtl/i2p_checker.sv =====
module i2p_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       has_symbol,
  input logic       run_last,
  input logic       postfix_end,
  input logic [1:0] status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(postfix_end))
    else $error("result changed while stalled");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && postfix_end |-> run_last && !has_symbol && out_symbol == 8'd0)
    else $error("malformed end marker");

  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_symbol |-> !postfix_end && status == i2p_pkg::ST_OK)
    else $error("character result with status or end flag");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_symbol  (out_chan.out_symbol),
  .has_symbol  (out_chan.has_symbol),
  .run_last    (out_chan.run_last),
  .postfix_end (out_chan.postfix_end),
  .status      (out_chan.status)
);
